[rtl/hvd_pkg.sv]
// Shared constants, widths and the CORDIC arctangent table for the haversine distance block.
package hvd_pkg;

  localparam int CORDIC_ITERATIONS_DEF   = 24;
  localparam int ANGLE_FRACTION_BITS_DEF = 22;

  localparam int LAT_W   = 30;
  localparam int LON_W   = 31;
  localparam int RAD_W   = 24;
  localparam int DIST_W  = 30;
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 32;

  // CORDIC datapath width, with headroom over the Q30 range and the CORDIC gain.
  localparam int XW = 34;

  localparam logic [31:0]          TURN_SCALE   = 32'd3054198966;
  localparam logic signed [XW-1:0] GAIN_Q30     = 34'sd652032874;
  localparam logic signed [XW-1:0] ONE_Q30      = 34'sd1073741824;
  localparam logic [30:0]          PI_Q29       = 31'd1686629713;
  localparam logic [RAD_W-1:0]     RADIUS_RESET = 24'd6371000;
  localparam logic [31:0]          DIST_MAX     = 32'd1073741823;

  typedef logic signed [31:0] q30_t;

  // Elementary angles atan(2^-i) in turns, 2^32 per turn.
  function automatic logic [XW-1:0] atan_turn(input int idx);
    logic [XW-1:0] val;
    case (idx)
      0:  val = 34'd536870912;
      1:  val = 34'd316933406;
      2:  val = 34'd167458907;
      3:  val = 34'd85004756;
      4:  val = 34'd42667331;
      5:  val = 34'd21354465;
      6:  val = 34'd10680862;
      7:  val = 34'd5340245;
      8:  val = 34'd2670163;
      9:  val = 34'd1335087;
      10: val = 34'd667544;
      11: val = 34'd333772;
      12: val = 34'd166886;
      13: val = 34'd83443;
      14: val = 34'd41722;
      15: val = 34'd20861;
      16: val = 34'd10430;
      17: val = 34'd5215;
      18: val = 34'd2608;
      19: val = 34'd1304;
      20: val = 34'd652;
      21: val = 34'd326;
      22: val = 34'd163;
      23: val = 34'd81;
      24: val = 34'd41;
      25: val = 34'd20;
      26: val = 34'd10;
      27: val = 34'd5;
      28: val = 34'd3;
      29: val = 34'd1;
      30: val = 34'd1;
      default: val = 34'd0;
    endcase
    return val;
  endfunction

endpackage

[rtl/hvd_turns.sv]
// Three-stage conversion of a fixed-point degree angle into binary turns.
module hvd_turns #(
  parameter int W                   = 30,
  parameter int ANGLE_FRACTION_BITS = 22
) (
  input  logic              clk,
  input  logic              en,
  input  logic [W-1:0]      raw,
  output logic [31:0]       turns
);
  import hvd_pkg::*;

  localparam int PW = W + 32;

  logic          neg1_r, neg2_r;
  logic [W-1:0]  mag_r;
  logic [PW-1:0] prod_r;
  logic [31:0]   turns_r;
  logic [63:0]   rnd;
  logic [31:0]   q;

  always_comb begin
    rnd = 64'(prod_r) + (64'd1 << (ANGLE_FRACTION_BITS + 7));
    q   = 32'(rnd >> (ANGLE_FRACTION_BITS + 8));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r  <= raw[W-1];
      mag_r   <= raw[W-1] ? (~raw + W'(1)) : raw;
      neg2_r  <= neg1_r;
      prod_r  <= PW'(mag_r) * PW'(TURN_SCALE);
      turns_r <= neg2_r ? (32'd0 - q) : q;
    end
  end

  assign turns = turns_r;
endmodule

[rtl/hvd_cordic_rot.sv]
// Pipelined rotation-mode CORDIC giving the sine and cosine of an angle in turns.
module hvd_cordic_rot #(
  parameter int CORDIC_ITERATIONS = 24
) (
  input  logic         clk,
  input  logic         en,
  input  logic [31:0]  ang,
  output hvd_pkg::q30_t sin_o,
  output hvd_pkg::q30_t cos_o
);
  import hvd_pkg::*;

  localparam int N = CORDIC_ITERATIONS;

  logic signed [XW-1:0] x_r [N];
  logic signed [XW-1:0] y_r [N];
  logic signed [XW-1:0] z_r [N];
  logic                 flip_r [N];
  q30_t                 sin_r, cos_r;

  logic                 flip0;
  logic [31:0]          ang0;
  logic signed [XW-1:0] z0;
  logic signed [XW-1:0] xc, yc;

  // Angles in the second and third quadrants are turned by half a turn first.
  always_comb begin
    flip0 = ang[31] ^ ang[30];
    ang0  = flip0 ? {~ang[31], ang[30:0]} : ang;
    z0    = XW'(signed'(ang0));
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [XW-1:0] xi, yi, zi;
    logic                 fi;
    localparam logic signed [XW-1:0] A = atan_turn(i);
    if (i == 0) begin : g_first
      assign xi = GAIN_Q30;
      assign yi = '0;
      assign zi = z0;
      assign fi = flip0;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign fi = flip_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        flip_r[i] <= fi;
        if (!zi[XW-1]) begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
          z_r[i] <= zi - A;
        end else begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
          z_r[i] <= zi + A;
        end
      end
    end
  end

  always_comb begin
    xc = (x_r[N-1] > ONE_Q30) ? ONE_Q30 : ((x_r[N-1] < -ONE_Q30) ? -ONE_Q30 : x_r[N-1]);
    yc = (y_r[N-1] > ONE_Q30) ? ONE_Q30 : ((y_r[N-1] < -ONE_Q30) ? -ONE_Q30 : y_r[N-1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= flip_r[N-1] ? q30_t'(-yc) : q30_t'(yc);
      cos_r <= flip_r[N-1] ? q30_t'(-xc) : q30_t'(xc);
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;
endmodule

[rtl/hvd_isqrt.sv]
// Pipelined 31-step digit-recurrence floor square root of a Q60 value.
module hvd_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [60:0] val,
  output logic [31:0] root
);
  import hvd_pkg::*;

  localparam int STEPS = 31;

  logic [61:0] v_r   [STEPS];
  logic [61:0] res_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [61:0] BITV = 62'd1 << (60 - 2 * k);
    logic [61:0] vi, ri, trial;
    if (k == 0) begin : g_first
      assign vi = 62'(val);
      assign ri = '0;
    end else begin : g_next
      assign vi = v_r[k-1];
      assign ri = res_r[k-1];
    end
    assign trial = ri + BITV;
    always_ff @(posedge clk) begin
      if (en) begin
        if (vi >= trial) begin
          v_r[k]   <= vi - trial;
          res_r[k] <= (ri >> 1) + BITV;
        end else begin
          v_r[k]   <= vi;
          res_r[k] <= ri >> 1;
        end
      end
    end
  end

  assign root = res_r[STEPS-1][31:0];
endmodule

[rtl/hvd_cordic_vec.sv]
// Pipelined vectoring-mode CORDIC giving atan2(y, x) in turns, clamped to a quarter turn.
module hvd_cordic_vec #(
  parameter int CORDIC_ITERATIONS = 24
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] y_in,
  input  logic [31:0] x_in,
  output logic [30:0] ang
);
  import hvd_pkg::*;

  localparam int N = CORDIC_ITERATIONS;

  logic signed [XW-1:0] x_r [N];
  logic signed [XW-1:0] y_r [N];
  logic signed [XW-1:0] z_r [N];
  logic [30:0]          ang_r;
  logic signed [XW-1:0] zl;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [XW-1:0] xi, yi, zi;
    localparam logic signed [XW-1:0] A = atan_turn(i);
    if (i == 0) begin : g_first
      assign xi = XW'(x_in);
      assign yi = XW'(y_in);
      assign zi = '0;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!yi[XW-1]) begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
          z_r[i] <= zi + A;
        end else begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
          z_r[i] <= zi - A;
        end
      end
    end
  end

  always_comb begin
    zl = z_r[N-1];
    if (zl[XW-1])     zl = '0;
    if (zl > ONE_Q30) zl = ONE_Q30;
  end

  always_ff @(posedge clk) begin
    if (en) ang_r <= zl[30:0];
  end

  assign ang = ang_r;
endmodule

[rtl/haversine_distance_top.sv]
// Top level of the pipelined haversine great-circle distance block.
//
//  channel | dir | fields (tdata, lowest bit up)
//  in_     | in  | first_lat[29:0] first_lon[60:30] second_lat[90:61] second_lon[121:91]
//  out_    | out | distance[29:0]
//  cfg_    | in  | sphere_radius_m[23:0]
//
// One transfer enters per cycle while no result is held at the output; a result passes through
// the two CORDIC chains and the 31-step square root pipeline.
// The pipeline advances as one whole; when a result is held at the output, it stops.
// Reset clears the valid bits and restores the default radius.
// The configuration channel is always ready.
module haversine_distance_top #(
  parameter int CORDIC_ITERATIONS   = hvd_pkg::CORDIC_ITERATIONS_DEF,
  parameter int ANGLE_FRACTION_BITS = hvd_pkg::ANGLE_FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // first_lat, first_lon, second_lat, second_lon, zero fill
  input  logic [hvd_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // distance, zero fill
  output logic [hvd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hvd_pkg::RAD_W-1:0]        cfg_data
);
  import hvd_pkg::*;

  localparam int LAT = 2 * CORDIC_ITERATIONS + 43;

  logic            en;
  logic [LAT-1:0]  vld_r;
  logic [RAD_W-1:0] radius_r;

  logic [31:0] lat1_t, lon1_t, lat2_t, lon2_t;
  logic [31:0] dlat_r, dlon_r, lat1_r, lat2_r;
  q30_t        s_lat, s_lon, c1, c2, s_un1, s_un2, c_un1, c_un2;

  logic signed [63:0] slat2_r, slon2_r, c12_r, slat2_d_r, tu_r;
  logic signed [63:0] t_v, u_v, a_sum;
  logic [60:0]        a_r, b_r;
  logic [31:0]        sq_a, sq_b;
  logic [30:0]        z;

  logic [54:0] p_r;
  logic [53:0] hi_r;
  logic [62:0] lo_r;
  logic [54:0] acc;
  logic [31:0] d;
  logic [DIST_W-1:0] dist_r;

  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      radius_r <= RADIUS_RESET;
    end else begin
      if (en) vld_r <= {vld_r[LAT-2:0], in_tvalid};
      if (cfg_valid) radius_r <= cfg_data;
    end
  end

  hvd_turns #(.W(LAT_W), .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_lat1 (
    .clk(clk), .en(en), .raw(in_tdata[29:0]), .turns(lat1_t));
  hvd_turns #(.W(LON_W), .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_lon1 (
    .clk(clk), .en(en), .raw(in_tdata[60:30]), .turns(lon1_t));
  hvd_turns #(.W(LAT_W), .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_lat2 (
    .clk(clk), .en(en), .raw(in_tdata[90:61]), .turns(lat2_t));
  hvd_turns #(.W(LON_W), .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_lon2 (
    .clk(clk), .en(en), .raw(in_tdata[121:91]), .turns(lon2_t));

  // Half differences wrap modulo a full turn before the halving.
  always_ff @(posedge clk) begin
    if (en) begin
      dlat_r <= (lat2_t - lat1_t) >> 1;
      dlon_r <= (lon2_t - lon1_t) >> 1;
      lat1_r <= lat1_t;
      lat2_r <= lat2_t;
    end
  end

  hvd_cordic_rot #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_rot_dlat (
    .clk(clk), .en(en), .ang(dlat_r), .sin_o(s_lat), .cos_o(c_un1));
  hvd_cordic_rot #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_rot_dlon (
    .clk(clk), .en(en), .ang(dlon_r), .sin_o(s_lon), .cos_o(c_un2));
  hvd_cordic_rot #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_rot_lat1 (
    .clk(clk), .en(en), .ang(lat1_r), .sin_o(s_un1), .cos_o(c1));
  hvd_cordic_rot #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_rot_lat2 (
    .clk(clk), .en(en), .ang(lat2_r), .sin_o(s_un2), .cos_o(c2));

  always_comb begin
    t_v   = c12_r >>> 30;
    u_v   = slon2_r >>> 30;
    a_sum = slat2_d_r + tu_r;
  end

  // Form a in Q60 over three stages and clamp it to [0, 1].
  always_ff @(posedge clk) begin
    if (en) begin
      slat2_r   <= {{32{s_lat[31]}}, s_lat} * {{32{s_lat[31]}}, s_lat};
      slon2_r   <= {{32{s_lon[31]}}, s_lon} * {{32{s_lon[31]}}, s_lon};
      c12_r     <= {{32{c1[31]}}, c1} * {{32{c2[31]}}, c2};
      slat2_d_r <= slat2_r;
      tu_r      <= {{32{t_v[31]}}, t_v[31:0]} * {{32{u_v[31]}}, u_v[31:0]};
      if (a_sum[63]) begin
        a_r <= '0;
        b_r <= 61'd1 << 60;
      end else if (a_sum > (64'sd1 <<< 60)) begin
        a_r <= 61'd1 << 60;
        b_r <= '0;
      end else begin
        a_r <= a_sum[60:0];
        b_r <= (61'd1 << 60) - a_sum[60:0];
      end
    end
  end

  hvd_isqrt u_sqrt_a (.clk(clk), .en(en), .val(a_r), .root(sq_a));
  hvd_isqrt u_sqrt_b (.clk(clk), .en(en), .val(b_r), .root(sq_b));

  hvd_cordic_vec #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_vec (
    .clk(clk), .en(en), .y_in(sq_a), .x_in(sq_b), .ang(z));

  always_comb begin
    acc = 55'(hi_r) + 55'(lo_r >> 32) + (55'd1 << 22);
    d   = acc[54:23];
  end

  // Scale by radius and pi, the 55-bit product split into two partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= 55'(radius_r) * 55'(z);
      hi_r   <= 54'(p_r[54:32]) * 54'(PI_Q29);
      lo_r   <= 63'(p_r[31:0]) * 63'(PI_Q29);
      dist_r <= (d > DIST_MAX) ? DIST_MAX[DIST_W-1:0] : d[DIST_W-1:0];
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = {{(OUT_TDATA_W - DIST_W){1'b0}}, dist_r};

`ifndef SYNTHESIS
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while the pipeline is stalled");
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted transfer lost its valid bit");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!en) |=> $stable(vld_r))
    else $error("valid bits moved during a stall");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[29:0] <= 30'd843316800))
    else $error("distance beyond a half circumference of the largest sphere");
`endif
endmodule

[tb/sv/tb_haversine_distance_top.sv]
// Self-checking testbench for the haversine distance block with random flow control.
`timescale 1ns / 100ps

module tb_haversine_distance_top;
  import hvd_pkg::*;

  localparam longint LAT_MAX = 377487360;
  localparam longint LON_MAX = 754974720;
  localparam int     DRAIN_CYCLES = 2 * CORDIC_ITERATIONS_DEF + 43 + 20;

  typedef struct {
    longint first_lat;
    longint first_lon;
    longint second_lat;
    longint second_lon;
  } point_pair_t;

  // Elementary angles in turns; only the first CORDIC_ITERATIONS_DEF are used.
  localparam longint ATAN_STEP [0:31] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0};

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [RAD_W-1:0]       cfg_data = '0;

  point_pair_t         pending_pairs[$];
  logic [DIST_W-1:0]   expected_dist[$];
  logic [RAD_W-1:0]    radius_m = RADIUS_RESET;
  int                  mismatches = 0;
  int                  in_gap = 0;
  int                  out_gap = 0;
  bit                  steady_flow = 1'b0;

  haversine_distance_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic longint floor_sra(longint v, int s);
    return v >>> s;
  endfunction

  // Degrees times 2^22 to binary turns, rounded on the magnitude.
  function automatic logic [31:0] deg_to_turns(longint v);
    longint unsigned mag, q;
    mag = (v < 0) ? -v : v;
    q = (mag * 64'd3054198966 + (64'd1 << 29)) >> 30;
    return (v < 0) ? (32'd0 - q[31:0]) : q[31:0];
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  function automatic void rotate_angle(input logic [31:0] ang, output longint s,
                                       output longint c);
    logic [1:0] quad;
    bit         flip;
    longint     x, y, z, dx, dy;
    quad = ang[31:30];
    flip = (quad == 2'd1 || quad == 2'd2);
    if (flip) ang = ang - 32'h8000_0000;
    x = 652032874;
    y = 0;
    z = longint'($signed(ang));
    for (int i = 0; i < CORDIC_ITERATIONS_DEF; i++) begin
      dx = floor_sra(y, i);
      dy = floor_sra(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_STEP[i];
      end else begin
        x += dx; y -= dy; z += ATAN_STEP[i];
      end
    end
    x = clamp_unit(x);
    y = clamp_unit(y);
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 60;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < CORDIC_ITERATIONS_DEF; i++) begin
      dx = floor_sra(y, i);
      dy = floor_sra(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_STEP[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_STEP[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 64'sd1073741824) z = 64'sd1073741824;
    return z;
  endfunction

  function automatic logic [DIST_W-1:0] great_circle_dist(point_pair_t p);
    logic [31:0]     lat1, lon1, lat2, lon2;
    longint          s_lat, s_lon, c1, c2, dummy, t, u, a60, z;
    longint unsigned prod, hi, lo, acc, d;
    lat1 = deg_to_turns(p.first_lat);
    lon1 = deg_to_turns(p.first_lon);
    lat2 = deg_to_turns(p.second_lat);
    lon2 = deg_to_turns(p.second_lon);
    rotate_angle((lat2 - lat1) >> 1, s_lat, dummy);
    rotate_angle((lon2 - lon1) >> 1, s_lon, dummy);
    rotate_angle(lat1, dummy, c1);
    rotate_angle(lat2, dummy, c2);
    t = floor_sra(c1 * c2, 30);
    u = (s_lon * s_lon) >>> 30;
    a60 = s_lat * s_lat + t * u;
    if (a60 < 0) a60 = 0;
    if (a60 > (64'sd1 << 60)) a60 = 64'sd1 << 60;
    z = vector_angle(floor_sqrt(a60), floor_sqrt((64'sd1 << 60) - a60));
    prod = longint'(radius_m) * z;
    hi = prod >> 32;
    lo = prod & 64'hFFFF_FFFF;
    acc = hi * 64'd1686629713 + ((lo * 64'd1686629713) >> 32) + (64'd1 << 22);
    d = acc >> 23;
    if (d > 64'd1073741823) d = 64'd1073741823;
    return d[DIST_W-1:0];
  endfunction

  // Input driver: a new item is offered only when the previous transfer is done.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        point_pair_t p;
        p = pending_pairs.pop_front();
        in_tdata <= {6'd0, p.second_lon[30:0], p.second_lat[29:0],
                     p.first_lon[30:0], p.first_lat[29:0]};
        in_tvalid <= 1'b1;
        expected_dist.insert(expected_dist.size(), great_circle_dist(p));
        in_gap <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_dist.size() == 0) begin
        $error("distance: unexpected transfer, actual %0d", out_tdata[DIST_W-1:0]);
        mismatches++;
      end else begin
        logic [DIST_W-1:0] want;
        want = expected_dist.pop_front();
        if (out_tdata[DIST_W-1:0] !== want) begin
          $error("distance: expected %0d, actual %0d", want, out_tdata[DIST_W-1:0]);
          mismatches++;
        end
      end
    end
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n;
      out_gap <= pick_gap();
    end
  end

  task automatic add_pair(longint a, longint b, longint c, longint d);
    point_pair_t p;
    p.first_lat = a; p.first_lon = b; p.second_lat = c; p.second_lon = d;
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  function automatic longint rand_field(int width, longint lim);
    longint v;
    int     r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      v = longint'({$urandom, $urandom}) & ((64'sd1 << width) - 1);
      if (v >= (64'sd1 << (width - 1))) v -= (64'sd1 << width);
      return v;
    end
    return longint'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  task automatic add_random_pairs(int n);
    longint a, b, c, d;
    repeat (n) begin
      a = rand_field(LAT_W, LAT_MAX);
      b = rand_field(LON_W, LON_MAX);
      if ($urandom_range(0, 3) == 0) begin
        // Nearby points: small distances stress the low end of the square root.
        c = a + longint'($urandom_range(0, 2000000)) - 1000000;
        d = b + longint'($urandom_range(0, 2000000)) - 1000000;
        if (c > LAT_MAX) c = LAT_MAX;
        if (c < -LAT_MAX) c = -LAT_MAX;
        if (d > LON_MAX) d = LON_MAX;
        if (d < -LON_MAX) d = -LON_MAX;
      end else begin
        c = rand_field(LAT_W, LAT_MAX);
        d = rand_field(LON_W, LON_MAX);
      end
      add_pair(a, b, c, d);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_pairs.size() != 0 || in_tvalid || expected_dist.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_radius(logic [RAD_W-1:0] r);
    cfg_valid <= 1'b1;
    cfg_data <= r;
    do @(posedge clk);
    while (!cfg_ready);
    radius_m = r;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [RAD_W-1:0] radii [0:4];
    radii = '{24'd1, 24'hFF_FFFF, 24'd0, 24'd6371000, 24'd0};
    radii[4] = $urandom_range(1, 24'hFF_FFFF);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pairs at the default radius.
    add_pair(0, 0, 0, 0);
    add_pair(LAT_MAX / 2, LON_MAX / 3, LAT_MAX / 2, LON_MAX / 3);
    add_pair(0, 0, 0, LON_MAX);
    add_pair(0, -LON_MAX, 0, LON_MAX);
    add_pair(LAT_MAX, 0, -LAT_MAX, 0);
    add_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
    add_pair(-LAT_MAX, 0, -LAT_MAX, LON_MAX / 2);
    add_pair(0, 0, 1, 1);
    add_pair(-(64'sd1 << 29), -(64'sd1 << 30), (64'sd1 << 29) - 1, (64'sd1 << 30) - 1);
    add_pair((64'sd1 << 29) - 1, (64'sd1 << 30) - 1, -(64'sd1 << 29), -(64'sd1 << 30));
    // Longitudes past the date line wrap; latitudes past the poles give negative cosines.
    add_pair(0, LON_MAX + 4194304, 0, -LON_MAX - 4194304);
    add_pair(LAT_MAX + 41943040, 0, LAT_MAX, LON_MAX / 4);
    add_pair(-LAT_MAX - 83886080, LON_MAX / 2, LAT_MAX + 83886080, -LON_MAX / 2);
    add_pair(LAT_MAX / 4, 0, -LAT_MAX / 4, LON_MAX);
    add_pair(-1, -1, 0, 0);
    add_pair(0, 0, -1, LON_MAX - 1);
    add_random_pairs(300);
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      write_radius(radii[ph]);
      steady_flow = (ph == 3);
      add_random_pairs(290);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[filelist.f]
rtl/hvd_pkg.sv
rtl/hvd_turns.sv
rtl/hvd_cordic_rot.sv
rtl/hvd_isqrt.sv
rtl/hvd_cordic_vec.sv
rtl/haversine_distance_top.sv
tb/sv/tb_haversine_distance_top.sv
